// ===== rtl/iniot_pkg.sv =====
package iniot_pkg;

	// line position field
	localparam int IDX_W = 10;
	localparam int IDX_MAX = (1 << IDX_W) - 1;
	localparam int MAX_LINE_LEN_DEF = 1024;

	// characters the parser reacts to
	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_BSLASH = 8'h5c;
	localparam logic [7:0] CH_EQUALS = 8'h3d;
	localparam logic [7:0] CH_SEMI = 8'h3b;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB = 8'h09;
	localparam logic [7:0] CH_LF = 8'h0a;
	localparam logic [7:0] CH_CR = 8'h0d;
	localparam logic [7:0] CH_NUL = 8'h00;

	// parse phase within one option line
	typedef enum logic [3:0] {
		PH_TINDENT = 4'd0,
		PH_TITLE_U = 4'd1,
		PH_TITLE_Q = 4'd2,
		PH_TAFTER = 4'd3,
		PH_VINDENT = 4'd4,
		PH_VALUE_U = 4'd5,
		PH_VALUE_Q = 4'd6,
		PH_VAFTER = 4'd7,
		PH_COMMENT = 4'd8,
		PH_DONE = 4'd9
	} phase_t;

	// character class reported per byte
	typedef enum logic [3:0] {
		CL_INDENT = 4'd0,
		CL_QUOTE = 4'd1,
		CL_TITLE = 4'd2,
		CL_EQUALS = 4'd3,
		CL_VALUE = 4'd4,
		CL_SEMI = 4'd5,
		CL_COMMENT = 4'd6,
		CL_LINEEND = 4'd7,
		CL_IGNORED = 4'd8
	} cls_t;

	// line error codes
	typedef enum logic [1:0] {
		ERR_OK = 2'd0,
		ERR_NO_EQUALS = 2'd1,
		ERR_NO_TERM = 2'd2
	} err_t;

	// outcome of classifying one byte
	typedef struct packed {
		phase_t next_phase;
		cls_t cls;
		err_t err;
	} step_res_t;

endpackage

// ===== rtl/iniot_step.sv =====
module iniot_step (
	input iniot_pkg::phase_t phase,
	input logic prev_bs,
	input logic [7:0] char_byte,
	input logic last_char,
	output iniot_pkg::step_res_t res
);
	import iniot_pkg::*;

	logic is_blank;
	logic is_eol;
	logic is_quote;
	logic is_eq;
	logic is_semi;
	logic closing;
	phase_t next_phase;
	cls_t cls;
	err_t err;

	// character decode
	assign is_blank = (char_byte == CH_SPACE) || (char_byte == CH_TAB);
	assign is_eol = (char_byte == CH_LF) || (char_byte == CH_CR) || (char_byte == CH_NUL);
	assign is_quote = (char_byte == CH_QUOTE);
	assign is_eq = (char_byte == CH_EQUALS);
	assign is_semi = (char_byte == CH_SEMI);
	assign closing = is_quote && !prev_bs;

	// next phase
	always_comb begin
		next_phase = phase;
		case (phase)
			PH_TINDENT: begin
				if (is_blank) next_phase = PH_TINDENT;
				else if (is_quote) next_phase = PH_TITLE_Q;
				else if (is_eq) next_phase = PH_VINDENT;
				else next_phase = PH_TITLE_U;
			end
			PH_TITLE_U: begin
				if (char_byte == CH_SPACE) next_phase = PH_TAFTER;
				else if (is_eq) next_phase = PH_VINDENT;
			end
			PH_TITLE_Q: begin
				if (closing) next_phase = PH_TAFTER;
			end
			PH_TAFTER: begin
				if (is_eq) next_phase = PH_VINDENT;
			end
			PH_VINDENT: begin
				if (is_blank) next_phase = PH_VINDENT;
				else if (is_quote) next_phase = PH_VALUE_Q;
				else if (is_semi) next_phase = PH_COMMENT;
				else if (is_eol) next_phase = PH_DONE;
				else next_phase = PH_VALUE_U;
			end
			PH_VALUE_U: begin
				if (is_blank) next_phase = PH_VAFTER;
				else if (is_semi) next_phase = PH_COMMENT;
				else if (is_eol) next_phase = PH_DONE;
			end
			PH_VALUE_Q: begin
				if (closing) next_phase = PH_VAFTER;
			end
			PH_VAFTER: begin
				if (is_semi) next_phase = PH_COMMENT;
				else if (is_eol) next_phase = PH_DONE;
			end
			PH_COMMENT: begin
				if (is_eol) next_phase = PH_DONE;
			end
			default: begin
				next_phase = PH_DONE;
			end
		endcase
	end

	// byte class
	always_comb begin
		cls = CL_IGNORED;
		case (phase)
			PH_TINDENT: begin
				if (is_blank) cls = CL_INDENT;
				else if (is_quote) cls = CL_QUOTE;
				else if (is_eq) cls = CL_EQUALS;
				else cls = CL_TITLE;
			end
			PH_TITLE_U: begin
				if (char_byte == CH_SPACE) cls = CL_IGNORED;
				else if (is_eq) cls = CL_EQUALS;
				else cls = CL_TITLE;
			end
			PH_TITLE_Q: begin
				cls = closing ? CL_QUOTE : CL_TITLE;
			end
			PH_TAFTER: begin
				cls = is_eq ? CL_EQUALS : CL_IGNORED;
			end
			PH_VINDENT: begin
				if (is_blank) cls = CL_INDENT;
				else if (is_quote) cls = CL_QUOTE;
				else if (is_semi) cls = CL_SEMI;
				else if (is_eol) cls = CL_LINEEND;
				else cls = CL_VALUE;
			end
			PH_VALUE_U: begin
				if (is_blank) cls = CL_IGNORED;
				else if (is_semi) cls = CL_SEMI;
				else if (is_eol) cls = CL_LINEEND;
				else cls = CL_VALUE;
			end
			PH_VALUE_Q: begin
				cls = closing ? CL_QUOTE : CL_VALUE;
			end
			PH_VAFTER: begin
				if (is_semi) cls = CL_SEMI;
				else if (is_eol) cls = CL_LINEEND;
				else cls = CL_IGNORED;
			end
			PH_COMMENT: begin
				cls = is_eol ? CL_LINEEND : CL_COMMENT;
			end
			default: begin
				cls = CL_IGNORED;
			end
		endcase
	end

	// line check on the final byte
	always_comb begin
		err = ERR_OK;
		if (last_char) begin
			if (next_phase inside {[PH_TINDENT:PH_TAFTER]}) err = ERR_NO_EQUALS;
			else if (next_phase inside {[PH_VINDENT:PH_VAFTER]}) err = ERR_NO_TERM;
		end
	end

	assign res = '{next_phase: next_phase, cls: cls, err: err};

endmodule

// ===== rtl/ini_option_line_tokenizer.sv =====
// INI option line tokenizer
//
// Feed the bytes of one option line on char_byte with in_valid/in_ready,
// marking the final byte with last_char. For every request taken, one
// result leaves on out_valid/out_ready: the byte's class, its position in
// the line, line_done for the final byte and an error code on that byte.
// Each result passes through the input register and then the result
// register. Throughput is one byte per cycle unless the receiver stalls;
// the only loop is the parse phase update, a few gates deep.
// When the receiver stalls, the result register holds, the input register
// takes one more byte, and in_ready drops until the result drains.
// Reset clears both registers' valid flags and returns the parser to the
// title indent phase at position zero; the same happens after each byte
// marked last_char. The position saturates at the smaller of
// MAX_LINE_LEN-1 and 1023.
module ini_option_line_tokenizer #(
	parameter int MAX_LINE_LEN = iniot_pkg::MAX_LINE_LEN_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input logic [7:0] char_byte,
	input logic last_char,
	output logic out_valid,
	input logic out_ready,
	output logic [3:0] char_class,
	output logic [iniot_pkg::IDX_W-1:0] char_index,
	output logic line_done,
	output logic [1:0] error_code
);
	import iniot_pkg::*;

	localparam int POS_LIMIT_INT = (MAX_LINE_LEN - 1 > IDX_MAX) ? IDX_MAX : MAX_LINE_LEN - 1;
	localparam logic [IDX_W-1:0] POS_LIMIT = IDX_W'(POS_LIMIT_INT);

	logic valid_s1;
	logic [7:0] byte_s1;
	logic last_s1;
	logic advance;
	logic valid_s2;
	cls_t cls_s2;
	logic [IDX_W-1:0] index_s2;
	logic done_s2;
	err_t err_s2;
	phase_t phase_q;
	logic prev_bs_q;
	logic [IDX_W-1:0] pos_q;
	step_res_t step;

	// the held byte moves on when the result register is free or draining
	assign advance = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= char_byte;
			last_s1 <= last_char;
		end
	end

	// classify against the current parse state
	iniot_step u_step (
		.phase(phase_q),
		.prev_bs(prev_bs_q),
		.char_byte(byte_s1),
		.last_char(last_s1),
		.res(step)
	);

	// parse state, back to line start after the final byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_TINDENT;
			prev_bs_q <= 1'b0;
			pos_q <= '0;
		end else if (advance) begin
			if (last_s1) begin
				phase_q <= PH_TINDENT;
				prev_bs_q <= 1'b0;
				pos_q <= '0;
			end else begin
				phase_q <= step.next_phase;
				prev_bs_q <= (byte_s1 == CH_BSLASH);
				if (pos_q < POS_LIMIT) pos_q <= pos_q + 1'b1;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (out_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			cls_s2 <= step.cls;
			index_s2 <= pos_q;
			done_s2 <= last_s1;
			err_s2 <= step.err;
		end
	end

	assign out_valid = valid_s2;
	assign char_class = cls_s2;
	assign char_index = index_s2;
	assign line_done = done_s2;
	assign error_code = err_s2;

	// a finished line leaves the parser at line start
	a_line_restart: assert property (@(posedge clk) disable iff (!arst_n)
		advance && last_s1 |=> phase_q == PH_TINDENT && pos_q == '0 && !prev_bs_q)
		else $error("parser state not cleared after final byte");

	// errors only on the final byte of a line
	a_err_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && err_s2 != ERR_OK |-> done_s2)
		else $error("error code on a byte that is not the last");

	// position never runs past its limit
	a_pos_limit: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= POS_LIMIT)
		else $error("line position beyond limit");

	// a byte waiting behind a stalled result is kept
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(byte_s1) && $stable(last_s1))
		else $error("held byte lost while result stalled");

endmodule

// ===== sim/tb_ini_option_line_tokenizer.sv =====
`timescale 1ns / 1ps

module tb_ini_option_line_tokenizer;
	import iniot_pkg::*;

	localparam int MAX_LEN = MAX_LINE_LEN_DEF;
	localparam int POS_LIMIT = (MAX_LEN - 1 > IDX_MAX) ? IDX_MAX : MAX_LEN - 1;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int RANDOM_BYTES = 600;
	localparam int LONG_COMMENT_LEN = 1040;

	// one classified byte as the block reports it
	typedef struct {
		cls_t cls;
		logic [IDX_W-1:0] idx;
		logic done;
		err_t err;
	} token_t;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	logic [7:0] char_byte;
	logic last_char;
	logic out_valid;
	logic out_ready;
	logic [3:0] char_class;
	logic [IDX_W-1:0] char_index;
	logic line_done;
	logic [1:0] error_code;

	// parser state mirrored by the predictor
	phase_t parse_phase;
	logic after_bslash;
	logic [IDX_W-1:0] line_pos;

	token_t pending_tokens[$];
	logic [7:0] line_buf[$];
	int mismatch_count;
	int bytes_sent;
	bit idle_on;

	ini_option_line_tokenizer #(
		.MAX_LINE_LEN(MAX_LEN)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.char_byte(char_byte),
		.last_char(last_char),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.char_class(char_class),
		.char_index(char_index),
		.line_done(line_done),
		.error_code(error_code)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic bit is_blank(input logic [7:0] c);
		return c == CH_SPACE || c == CH_TAB;
	endfunction

	function automatic bit is_eol(input logic [7:0] c);
		return c == CH_LF || c == CH_CR || c == CH_NUL;
	endfunction

	// unquoted title byte
	function automatic cls_t title_text(input logic [7:0] c);
		if (c == CH_SPACE) begin
			parse_phase = PH_TAFTER;
			return CL_IGNORED;
		end
		if (c == CH_EQUALS) begin
			parse_phase = PH_VINDENT;
			return CL_EQUALS;
		end
		return CL_TITLE;
	endfunction

	// unquoted value byte
	function automatic cls_t value_text(input logic [7:0] c);
		if (is_blank(c)) begin
			parse_phase = PH_VAFTER;
			return CL_IGNORED;
		end
		if (c == CH_SEMI) begin
			parse_phase = PH_COMMENT;
			return CL_SEMI;
		end
		if (is_eol(c)) begin
			parse_phase = PH_DONE;
			return CL_LINEEND;
		end
		return CL_VALUE;
	endfunction

	function automatic void clear_parser();
		parse_phase = PH_TINDENT;
		after_bslash = 1'b0;
		line_pos = '0;
	endfunction

	// classify one byte and advance the mirrored parser
	function automatic token_t classify_byte(input logic [7:0] c, input logic last);
		token_t r;
		logic closing;
		closing = (c == CH_QUOTE) && !after_bslash;
		r.idx = line_pos;
		r.done = last;
		r.err = ERR_OK;
		case (parse_phase)
			PH_TINDENT: begin
				if (is_blank(c)) begin
					r.cls = CL_INDENT;
				end else if (c == CH_QUOTE) begin
					parse_phase = PH_TITLE_Q;
					r.cls = CL_QUOTE;
				end else begin
					parse_phase = PH_TITLE_U;
					r.cls = title_text(c);
				end
			end
			PH_TITLE_U: begin
				r.cls = title_text(c);
			end
			PH_TITLE_Q: begin
				if (closing) begin
					parse_phase = PH_TAFTER;
					r.cls = CL_QUOTE;
				end else begin
					r.cls = CL_TITLE;
				end
			end
			PH_TAFTER: begin
				if (c == CH_EQUALS) begin
					parse_phase = PH_VINDENT;
					r.cls = CL_EQUALS;
				end else begin
					r.cls = CL_IGNORED;
				end
			end
			PH_VINDENT: begin
				if (is_blank(c)) begin
					r.cls = CL_INDENT;
				end else if (c == CH_QUOTE) begin
					parse_phase = PH_VALUE_Q;
					r.cls = CL_QUOTE;
				end else begin
					parse_phase = PH_VALUE_U;
					r.cls = value_text(c);
				end
			end
			PH_VALUE_U: begin
				r.cls = value_text(c);
			end
			PH_VALUE_Q: begin
				if (closing) begin
					parse_phase = PH_VAFTER;
					r.cls = CL_QUOTE;
				end else begin
					r.cls = CL_VALUE;
				end
			end
			PH_VAFTER: begin
				if (c == CH_SEMI) begin
					parse_phase = PH_COMMENT;
					r.cls = CL_SEMI;
				end else if (is_eol(c)) begin
					parse_phase = PH_DONE;
					r.cls = CL_LINEEND;
				end else begin
					r.cls = CL_IGNORED;
				end
			end
			PH_COMMENT: begin
				if (is_eol(c)) begin
					parse_phase = PH_DONE;
					r.cls = CL_LINEEND;
				end else begin
					r.cls = CL_COMMENT;
				end
			end
			default: begin
				parse_phase = PH_DONE;
				r.cls = CL_IGNORED;
			end
		endcase
		// error codes only on the final byte
		if (last) begin
			if (parse_phase <= PH_TAFTER)
				r.err = ERR_NO_EQUALS;
			else if (parse_phase <= PH_VAFTER)
				r.err = ERR_NO_TERM;
		end
		if (last) begin
			clear_parser();
		end else begin
			after_bslash = (c == CH_BSLASH);
			if (line_pos < POS_LIMIT)
				line_pos = line_pos + 1'b1;
		end
		return r;
	endfunction

	// send one request, with an optional gap before it
	task automatic send_byte(input logic [7:0] c, input logic last);
		int gap;
		@(negedge clk);
		if (idle_on && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 16);
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid = 1'b1;
		char_byte = c;
		last_char = last;
		do @(posedge clk); while (!in_ready);
		pending_tokens.push_back(classify_byte(c, last));
		bytes_sent++;
	endtask

	// send the buffered line, final byte marked
	task automatic send_line();
		for (int i = 0; i < line_buf.size(); i++)
			send_byte(line_buf[i], i == line_buf.size() - 1);
		line_buf.delete();
	endtask

	task automatic load_text(input string s);
		for (int i = 0; i < s.len(); i++)
			line_buf.push_back(s[i]);
	endtask

	// hold the sender until every result is back
	task automatic wait_drained();
		@(negedge clk);
		in_valid = 1'b0;
		while (pending_tokens.size() != 0) @(posedge clk);
	endtask

	function automatic logic [7:0] pick_blank();
		return $urandom_range(0, 1) ? CH_SPACE : CH_TAB;
	endfunction

	function automatic logic [7:0] pick_eol();
		case ($urandom_range(0, 2))
			0: return CH_LF;
			1: return CH_CR;
			default: return CH_NUL;
		endcase
	endfunction

	// mostly letters, sometimes a byte the parser reacts to
	function automatic logic [7:0] pick_text();
		case ($urandom_range(0, 19))
			0: return CH_BSLASH;
			1: return CH_QUOTE;
			2: return CH_EQUALS;
			3: return CH_SEMI;
			4: return pick_blank();
			5: return pick_eol();
			6, 7: return 8'($urandom_range(0, 255));
			default: return 8'($urandom_range(8'h61, 8'h7a));
		endcase
	endfunction

	// title or value, quoted or not
	task automatic load_field(input bit quoted);
		int n;
		n = $urandom_range(1, 5);
		if (quoted) begin
			line_buf.push_back(CH_QUOTE);
			repeat (n) begin
				if ($urandom_range(0, 5) == 0) begin
					line_buf.push_back(CH_BSLASH);
					line_buf.push_back(CH_QUOTE);
				end else begin
					line_buf.push_back(pick_text());
				end
			end
			if ($urandom_range(0, 7) != 0)
				line_buf.push_back(CH_QUOTE);
		end else begin
			repeat (n) line_buf.push_back(8'($urandom_range(8'h61, 8'h7a)));
			if ($urandom_range(0, 3) == 0)
				line_buf.push_back(pick_text());
		end
	endtask

	// option line with random content, sometimes broken
	task automatic load_option_line();
		repeat ($urandom_range(0, 2)) line_buf.push_back(pick_blank());
		load_field($urandom_range(0, 2) == 0);
		repeat ($urandom_range(0, 2)) line_buf.push_back(CH_SPACE);
		if ($urandom_range(0, 9) != 0)
			line_buf.push_back(CH_EQUALS);
		repeat ($urandom_range(0, 2)) line_buf.push_back(pick_blank());
		load_field($urandom_range(0, 2) == 0);
		case ($urandom_range(0, 4))
			0: ;
			1: begin
				line_buf.push_back(pick_blank());
				repeat ($urandom_range(0, 2)) line_buf.push_back(pick_text());
				line_buf.push_back(CH_SEMI);
				repeat ($urandom_range(0, 4)) line_buf.push_back(pick_text());
			end
			2: begin
				line_buf.push_back(CH_SEMI);
				repeat ($urandom_range(0, 4)) line_buf.push_back(pick_text());
			end
			3: line_buf.push_back(pick_eol());
			default: begin
				line_buf.push_back(CH_SEMI);
				repeat ($urandom_range(0, 3)) line_buf.push_back(pick_text());
				line_buf.push_back(pick_eol());
				repeat ($urandom_range(0, 3)) line_buf.push_back(8'($urandom_range(0, 255)));
			end
		endcase
	endtask

	// unquoted option with indents, terminator, comment, cr and junk after it
	task automatic test_plain_option();
		load_text(" a =");
		line_buf.push_back(CH_TAB);
		load_text("b ;c");
		line_buf.push_back(CH_CR);
		line_buf.push_back(8'hff);
		send_line();
	endtask

	// escaped quote and equals inside a quoted title, semicolon in quoted value
	task automatic test_quoted_option();
		line_buf.push_back(CH_QUOTE);
		load_text("q");
		line_buf.push_back(CH_BSLASH);
		line_buf.push_back(CH_QUOTE);
		line_buf.push_back(CH_EQUALS);
		line_buf.push_back(CH_QUOTE);
		line_buf.push_back(CH_EQUALS);
		line_buf.push_back(CH_QUOTE);
		load_text("v;");
		line_buf.push_back(CH_QUOTE);
		send_line();
	endtask

	// missing equals, equals as last byte, nul end, comment without line end
	task automatic test_short_lines();
		line_buf.push_back(CH_LF);
		send_line();
		load_text("k=");
		send_line();
		line_buf.push_back(CH_EQUALS);
		line_buf.push_back(CH_NUL);
		send_line();
		load_text("=;");
		send_line();
	endtask

	// mostly option lines, some pure noise
	task automatic test_random_lines();
		bit paused;
		paused = 0;
		while (bytes_sent < RANDOM_BYTES) begin
			idle_on = ($urandom_range(0, 3) != 0);
			if ($urandom_range(0, 7) == 0) begin
				repeat ($urandom_range(1, 12))
					line_buf.push_back(8'($urandom_range(0, 255)));
			end else begin
				load_option_line();
			end
			send_line();
			if (!paused && bytes_sent > RANDOM_BYTES / 2) begin
				wait_drained();
				paused = 1;
			end
		end
	endtask

	// line longer than the position field, back to back
	task automatic test_position_saturation();
		idle_on = 0;
		load_text("k=v;");
		repeat (LONG_COMMENT_LEN) line_buf.push_back(8'($urandom_range(8'h20, 8'h7e)));
		send_line();
		load_text("x=y");
		line_buf.push_back(CH_LF);
		send_line();
	endtask

	// compare each result with the oldest prediction
	always @(posedge clk) begin
		token_t exp;
		if (arst_n && out_valid && out_ready) begin
			if (pending_tokens.size() == 0) begin
				if (mismatch_count < 10)
					$display("unexpected result: cls=%0d idx=%0d done=%0b err=%0d",
						char_class, char_index, line_done, error_code);
				mismatch_count++;
			end else begin
				exp = pending_tokens.pop_front();
				if (char_class !== exp.cls || char_index !== exp.idx ||
						line_done !== exp.done || error_code !== exp.err) begin
					if (mismatch_count < 10)
						$display("mismatch: exp cls=%0d idx=%0d done=%0b err=%0d, got cls=%0d idx=%0d done=%0b err=%0d",
							exp.cls, exp.idx, exp.done, exp.err,
							char_class, char_index, line_done, error_code);
					mismatch_count++;
				end
			end
		end
	end

	// receiver stalls in random bursts
	initial begin
		int stall;
		stall = 0;
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (stall == 0 && idle_on && arst_n && $urandom_range(0, 5) == 0)
				stall = $urandom_range(1, 16);
			if (stall > 0) begin
				out_ready = 1'b0;
				stall--;
			end else begin
				out_ready = 1'b1;
			end
		end
	end

	// watchdog on cycles with no request moving on either side
	initial begin
		int quiet;
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("FAIL ini_option_line_tokenizer");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		char_byte = '0;
		last_char = 1'b0;
		idle_on = 1;
		mismatch_count = 0;
		bytes_sent = 0;
		clear_parser();
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_plain_option();
		test_quoted_option();
		test_short_lines();
		test_random_lines();
		test_position_saturation();

		// let the pipeline empty, then let the clock run on before the verdict
		@(negedge clk);
		in_valid = 1'b0;
		while (pending_tokens.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (mismatch_count == 0)
			$display("PASS ini_option_line_tokenizer");
		else
			$display("FAIL ini_option_line_tokenizer");
		$finish;
	end

endmodule
